### rtl/ifss_pkg.sv
// Package for the integer format size selector.
// Holds the request and response types, the stage types and the format codes.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package ifss_pkg;

  // Number of formats that are sized for each value.
  localparam int NUM_FORMATS = 7;

  // Number of 7-bit groups above the first one in a 64-bit value.
  localparam int NUM_GROUPS = 9;

  // Format codes.
  localparam logic [2:0] FMT_U8     = 3'd0;
  localparam logic [2:0] FMT_SLEB32 = 3'd1;
  localparam logic [2:0] FMT_ULEB32 = 3'd2;
  localparam logic [2:0] FMT_U32    = 3'd3;
  localparam logic [2:0] FMT_SLEB64 = 3'd4;
  localparam logic [2:0] FMT_ULEB64 = 3'd5;
  localparam logic [2:0] FMT_U64    = 3'd6;
  localparam logic [2:0] FMT_NONE   = 3'd7;

  // Fixed byte sizes of the plain formats.
  localparam logic [3:0] U32_BYTES = 4'd4;
  localparam logic [3:0] U64_BYTES = 4'd8;

  // One request: the value to classify and the queried format.
  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  query_format;
  } ifss_req_t;

  // One response: all sizes and both selected formats.
  typedef struct packed {
    logic       size_u8;
    logic [2:0] size_sleb32;
    logic [2:0] size_uleb32;
    logic [2:0] size_u32;
    logic [3:0] size_sleb64;
    logic [3:0] size_uleb64;
    logic [3:0] size_u64;
    logic [2:0] min_format;
    logic [2:0] next_match_format;
  } ifss_rsp_t;

  // First stage result: range flags and an unsigned and a signed flag per 7-bit group.
  typedef struct packed {
    logic                  fits_u8;
    logic                  fits_u32;
    logic                  fits_s32;
    logic [NUM_GROUPS-1:0] ugrp;
    logic [NUM_GROUPS-1:0] sgrp;
    logic [2:0]            query_format;
  } ifss_flags_t;

  // Second stage result: the byte size of every format.
  typedef struct packed {
    logic [NUM_FORMATS-1:0][3:0] sz;
    logic [2:0]                  query_format;
  } ifss_sizes_t;

endpackage

`default_nettype wire

### rtl/ifss_scan.sv
// First pipeline stage: range checks and 7-bit group occupancy of the value.
// Depends on ifss_pkg for the request and flag types.
`default_nettype none

module ifss_scan import ifss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire ifss_req_t   up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output ifss_flags_t      dn_data
);

  logic [63:0] mag;
  ifss_flags_t flags_next;
  logic        vld;
  ifss_flags_t flags;

  // A negative value is measured through its complement for the signed forms.
  always_comb begin
    mag = up_data.value[63] ? ~up_data.value : up_data.value;
    flags_next.fits_u8  = (up_data.value[63:8] == 56'd0);
    flags_next.fits_u32 = (up_data.value[63:32] == 32'd0);
    flags_next.fits_s32 = (&up_data.value[63:31]) || (up_data.value[63:31] == 33'd0);
    for (int k = 1; k <= NUM_GROUPS; k++) begin
      // Unsigned form needs byte k+1 when bits at 7k and above are set.
      flags_next.ugrp[k-1] = |(up_data.value >> (7 * k));
      // Signed form also needs room for the sign bit.
      flags_next.sgrp[k-1] = |(mag >> (7 * k - 1));
    end
    flags_next.query_format = up_data.query_format;
  end

  // Stage register; it takes a new request whenever it is empty or draining.
  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      flags <= flags_next;
    end
  end

  assign dn_valid = vld;
  assign dn_data  = flags;

endmodule

`default_nettype wire

### rtl/ifss_size.sv
// Second pipeline stage: turns group flags into byte sizes for all formats.
// Depends on ifss_pkg for the flag and size types.
`default_nettype none

module ifss_size import ifss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire ifss_flags_t up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output ifss_sizes_t      dn_data
);

  logic [3:0]  uleb;
  logic [3:0]  sleb;
  ifss_sizes_t sizes_next;
  logic        vld;
  ifss_sizes_t sizes;

  // Group flags are monotone, so the byte count is one plus the set flags.
  always_comb begin
    uleb = 4'd1 + 4'($countones(up_data.ugrp));
    sleb = 4'd1 + 4'($countones(up_data.sgrp));
    sizes_next.sz[FMT_U8]     = {3'd0, up_data.fits_u8};
    sizes_next.sz[FMT_SLEB32] = up_data.fits_s32 ? sleb : 4'd0;
    sizes_next.sz[FMT_ULEB32] = up_data.fits_u32 ? uleb : 4'd0;
    sizes_next.sz[FMT_U32]    = up_data.fits_u32 ? U32_BYTES : 4'd0;
    sizes_next.sz[FMT_SLEB64] = sleb;
    sizes_next.sz[FMT_ULEB64] = uleb;
    sizes_next.sz[FMT_U64]    = U64_BYTES;
    sizes_next.query_format   = up_data.query_format;
  end

  // Stage register with the same hand-off rule as the other stages.
  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sizes <= sizes_next;
    end
  end

  assign dn_valid = vld;
  assign dn_data  = sizes;

endmodule

`default_nettype wire

### rtl/ifss_pick.sv
// Third pipeline stage: picks the smallest format and the next matching one,
// and holds the response register. Depends on ifss_pkg.
`default_nettype none

module ifss_pick import ifss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire ifss_sizes_t up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output ifss_rsp_t        dn_data
);

  logic [3:0] mins;
  logic [2:0] minf;
  logic [3:0] qsz;
  logic [2:0] nxt;
  ifss_rsp_t  rsp_next;
  logic       vld;
  ifss_rsp_t  rsp;

  // Minimum search keeps the first format on ties; uint64 is always valid.
  always_comb begin
    mins = 4'hF;
    minf = FMT_U64;
    for (int i = 0; i < NUM_FORMATS; i++) begin
      if (up_data.sz[i] != 4'd0 && up_data.sz[i] < mins) begin
        mins = up_data.sz[i];
        minf = 3'(i);
      end
    end
  end

  // Next match scans downward so that the lowest higher format wins.
  always_comb begin
    qsz = 4'd0;
    for (int i = 0; i < NUM_FORMATS; i++) begin
      if (up_data.query_format == 3'(i)) begin
        qsz = up_data.sz[i];
      end
    end
    nxt = up_data.query_format;
    if (up_data.query_format != FMT_NONE) begin
      for (int i = NUM_FORMATS - 1; i >= 0; i--) begin
        if (3'(i) > up_data.query_format && up_data.sz[i] == qsz) begin
          nxt = 3'(i);
        end
      end
    end
  end

  // Pack the response fields at their port widths.
  always_comb begin
    rsp_next.size_u8           = up_data.sz[FMT_U8][0];
    rsp_next.size_sleb32       = up_data.sz[FMT_SLEB32][2:0];
    rsp_next.size_uleb32       = up_data.sz[FMT_ULEB32][2:0];
    rsp_next.size_u32          = up_data.sz[FMT_U32][2:0];
    rsp_next.size_sleb64       = up_data.sz[FMT_SLEB64];
    rsp_next.size_uleb64       = up_data.sz[FMT_ULEB64];
    rsp_next.size_u64          = up_data.sz[FMT_U64];
    rsp_next.min_format        = minf;
    rsp_next.next_match_format = nxt;
  end

  // Output register; it refills in the cycle the receiver takes a response.
  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rsp <= rsp_next;
    end
  end

  assign dn_valid = vld;
  assign dn_data  = rsp;

`ifndef SYNTHESIS
  // The selected minimum format never points at uint8 for a value that does not fit it.
  assert property (@(posedge clk) disable iff (rst)
    (vld && rsp.min_format == FMT_U8) |-> rsp.size_u8)
    else $error("min_format selects uint8 for a value that does not fit");

  // A value that fits uint8 always has uint8 as its smallest format.
  assert property (@(posedge clk) disable iff (rst)
    (vld && rsp.size_u8) |-> rsp.min_format == FMT_U8)
    else $error("uint8 fits but was not chosen as minimum");

  // A value too wide for uint32 has no unsigned 32-bit LEB128 size and does not fit uint8.
  assert property (@(posedge clk) disable iff (rst)
    (vld && rsp.size_u32 == 3'd0) |-> (rsp.size_uleb32 == 3'd0 && !rsp.size_u8))
    else $error("32-bit sizes disagree");

  // The next match is never below the queried format.
  assert property (@(posedge clk) disable iff (rst)
    (up_ready && up_valid) |=> rsp.next_match_format >= $past(up_data.query_format))
    else $error("next match below query");
`endif

endmodule

`default_nettype wire

### rtl/integer_format_size_selector.sv
// Integer format size selector.
// Each request carries a 64-bit value and a queried format code. The response
// gives the byte size of the value as uint8, signed and unsigned LEB128 of a
// 32-bit value, uint32, signed and unsigned LEB128 of a 64-bit value and
// uint64, with 0 where the value does not fit. It also names the lowest
// format of smallest size and the next higher format whose size equals the
// queried format's size (the query itself if there is none).
// Both channels use valid/ready; a request moves when valid and ready are high.
// The block is a three-stage pipeline: range scan, size encode, selection.
// A request passes the scan, size and pick stage registers in that order; one
// request is taken every cycle while responses are taken every cycle.
// Each stage register loads when it is empty or when the next stage takes its
// content, so a stalled receiver holds the response and fills the empty stages
// behind it before req_ready falls. Reset is synchronous and empties all stages.
// Depends on ifss_pkg and the stage modules ifss_scan, ifss_size, ifss_pick.
`default_nettype none

module integer_format_size_selector import ifss_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire ifss_req_t req_data,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output ifss_rsp_t      rsp_data
);

  logic        s1_valid;
  logic        s1_ready;
  ifss_flags_t s1_data;
  logic        s2_valid;
  logic        s2_ready;
  ifss_sizes_t s2_data;

  // Range and group scan of the incoming value.
  ifss_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_data  (req_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Byte sizes per format.
  ifss_size u_size (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Format selection and response register.
  ifss_pick u_pick (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (rsp_valid),
    .dn_ready (rsp_ready),
    .dn_data  (rsp_data)
  );

endmodule

`default_nettype wire
